// ===== rtl/rkqb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rkqb_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned SPD_W      = 3;
    localparam int unsigned GRACE_W    = 12;
    localparam int unsigned TIME_W     = 16;
    localparam int unsigned ACC_W      = 4;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_DETENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE_MS         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_HOLD_MS    = 3'd4;

    localparam logic [SPD_W-1:0]   SPD_MIN           = 3'd1;
    localparam logic [SPD_W-1:0]   SPD_MAX           = 3'd4;
    localparam logic [SPD_W-1:0]   SPD_RESET         = 3'd4;
    localparam logic [GRACE_W-1:0] GRACE_RESET       = 12'd2000;
    localparam logic [TIME_W-1:0]  DEBOUNCE_RESET    = 16'd30;
    localparam logic [TIME_W-1:0]  HOLD_RESET        = 16'd600;
    localparam logic [TIME_W-1:0]  SLEEP_HOLD_RESET  = 16'd3000;
    localparam logic [1:0]         PHASES_RESET      = 2'b11;

    typedef struct packed {
        logic [TIME_W-1:0] debounce_ms;
        logic [TIME_W-1:0] hold_ms;
        logic [TIME_W-1:0] sleep_hold_ms;
    } rkqb_btn_cfg_t;

    typedef struct packed {
        logic accept;
        logic enabled;
        logic level;
        logic tick;
    } rkqb_btn_in_t;

    typedef struct packed {
        logic press;
        logic hold;
        logic sleep;
    } rkqb_btn_out_t;

    // packed with step in the lowest bits
    typedef struct packed {
        logic              input_enabled;
        logic              sleep_pulse;
        logic              hold_level;
        logic              press_pulse;
        logic signed [1:0] step;
    } rkqb_result_t;

    // quadrature transition table, index = {previous A, previous B, A, B}
    function automatic logic signed [1:0] gray_delta(input logic [3:0] idx);
        logic signed [1:0] d;
        begin
            unique case (idx)
                4'd1, 4'd7, 4'd8, 4'd14:  d = -2'sd1;
                4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
                default:                  d = 2'sd0;
            endcase
            return d;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rkqb_button.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rkqb_button (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire rkqb_pkg::rkqb_btn_cfg_t cfg,
    input  wire rkqb_pkg::rkqb_btn_in_t  btn_in,
    output rkqb_pkg::rkqb_btn_out_t      btn_out
);
    import rkqb_pkg::*;

    logic              down_reg,  down_next;
    logic [TIME_W-1:0] time_reg,  time_next;
    logic              hold_reg,  hold_next;
    logic              sleep_reg, sleep_next;
    logic              press;
    logic              sleep;

    always_comb
    begin
        down_next  = down_reg;
        time_next  = time_reg;
        hold_next  = hold_reg;
        sleep_next = sleep_reg;
        press      = 1'b0;
        sleep      = 1'b0;
        if (!btn_in.enabled)
        begin
            down_next  = 1'b0;
            time_next  = '0;
            hold_next  = 1'b0;
            sleep_next = 1'b0;
        end
        else
        begin
            if (btn_in.level && !down_reg)
            begin
                down_next  = 1'b1;
                time_next  = '0;
                hold_next  = 1'b0;
                sleep_next = 1'b0;
            end
            else if (down_reg)
            begin
                if (btn_in.tick && (time_reg != '1))
                begin
                    time_next = time_reg + TIME_W'(1);
                end
                if (!btn_in.level)
                begin
                    press = (time_next >= cfg.debounce_ms) && (time_next < cfg.hold_ms)
                            && !sleep_reg;
                    down_next = 1'b0;
                    hold_next = 1'b0;
                end
                else if (!hold_reg && (time_next >= cfg.hold_ms))
                begin
                    hold_next = 1'b1;
                end
            end
            if (down_next && !sleep_next && (time_next >= cfg.sleep_hold_ms))
            begin
                sleep_next = 1'b1;
                sleep      = 1'b1;
            end
        end
    end

    assign btn_out.press = press;
    assign btn_out.hold  = hold_next;
    assign btn_out.sleep = sleep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg  <= 1'b0;
            time_reg  <= '0;
            hold_reg  <= 1'b0;
            sleep_reg <= 1'b0;
        end
        else if (btn_in.accept)
        begin
            down_reg  <= down_next;
            time_reg  <= time_next;
            hold_reg  <= hold_next;
            sleep_reg <= sleep_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rotary_knob_quadrature_and_button.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one sample per cycle while the skid register is empty; state is updated
// in the accept cycle and the result goes to an output register backed by a one-beat
// skid register. Reset: asynchronous, active low; all registers but the output and skid
// data registers take their reset values, phases read as both high, the grace counter
// starts from zero and no result beat is pending.
module rotary_knob_quadrature_and_button (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // [0] phase_a, [1] phase_b, [2] button_level, [3] ms_tick, [7:4] zero
    input  wire  [rkqb_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [1:0] step, [2] press_pulse, [3] hold_level, [4] sleep_pulse,
    // [5] input_enabled, [7:6] zero
    output logic [rkqb_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [rkqb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [rkqb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rkqb_pkg::*;

    // config
    logic [SPD_W-1:0]   spd_reg;
    logic [GRACE_W-1:0] grace_ms_reg;
    logic [TIME_W-1:0]  debounce_reg;
    logic [TIME_W-1:0]  hold_ms_reg;
    logic [TIME_W-1:0]  sleep_ms_reg;
    logic [SPD_W-1:0]   spd_wr;
    logic               cfg_fire;

    // item state
    logic [1:0]              phases_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [GRACE_W-1:0]      grace_reg, grace_next;

    logic               in_fire;
    logic               out_fire;
    logic [1:0]         phases;
    logic               level;
    logic               tick;
    logic               enabled;
    logic signed [1:0]  delta;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] spd_s;
    logic signed [1:0]  step;
    rkqb_result_t       result;
    rkqb_btn_cfg_t      btn_cfg;
    rkqb_btn_in_t       btn_in;
    rkqb_btn_out_t      btn_out;

    // output register and skid
    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    rkqb_result_t       out_data_reg, out_data_next;
    rkqb_result_t       skid_data_reg, skid_data_next;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    always_comb
    begin
        spd_wr = cfg_data[SPD_W-1:0];
        if (spd_wr < SPD_MIN)
        begin
            spd_wr = SPD_MIN;
        end
        else if (spd_wr > SPD_MAX)
        begin
            spd_wr = SPD_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spd_reg      <= SPD_RESET;
            grace_ms_reg <= GRACE_RESET;
            debounce_reg <= DEBOUNCE_RESET;
            hold_ms_reg  <= HOLD_RESET;
            sleep_ms_reg <= SLEEP_HOLD_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_STEPS_PER_DETENT: spd_reg      <= spd_wr;
                CFG_GRACE_MS:         grace_ms_reg <= cfg_data[GRACE_W-1:0];
                CFG_DEBOUNCE_MS:      debounce_reg <= cfg_data[TIME_W-1:0];
                CFG_HOLD_MS:          hold_ms_reg  <= cfg_data[TIME_W-1:0];
                CFG_SLEEP_HOLD_MS:    sleep_ms_reg <= cfg_data[TIME_W-1:0];
                default:              ;
            endcase
        end
    end

    assign in_fire  = s_tvalid & s_tready;
    assign out_fire = m_tvalid & m_tready;

    assign phases = {s_tdata[0], s_tdata[1]};
    assign level  = s_tdata[2];
    assign tick   = s_tdata[3];

    assign grace_next = (tick && (grace_reg != '1)) ? grace_reg + GRACE_W'(1) : grace_reg;
    assign enabled    = grace_next >= grace_ms_reg;

    assign delta   = gray_delta({phases_reg, phases});
    assign acc_sum = acc_reg + ACC_W'(delta);
    assign spd_s   = $signed({1'b0, spd_reg});

    always_comb
    begin
        step     = 2'sd0;
        acc_next = acc_sum;
        if (!enabled)
        begin
            acc_next = '0;
        end
        else if (acc_sum >= spd_s)
        begin
            step     = 2'sd1;
            acc_next = acc_sum - spd_s;
        end
        else if (acc_sum <= -spd_s)
        begin
            step     = -2'sd1;
            acc_next = acc_sum + spd_s;
        end
    end

    assign btn_cfg.debounce_ms   = debounce_reg;
    assign btn_cfg.hold_ms       = hold_ms_reg;
    assign btn_cfg.sleep_hold_ms = sleep_ms_reg;

    assign btn_in.accept  = in_fire;
    assign btn_in.enabled = enabled;
    assign btn_in.level   = level;
    assign btn_in.tick    = tick;

    rkqb_button u_button (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (btn_cfg),
        .btn_in  (btn_in),
        .btn_out (btn_out)
    );

    always_comb
    begin
        result.step          = step;
        result.press_pulse   = btn_out.press;
        result.hold_level    = btn_out.hold;
        result.sleep_pulse   = btn_out.sleep;
        result.input_enabled = 1'b1;
        if (!enabled)
        begin
            result = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phases_reg <= PHASES_RESET;
            acc_reg    <= '0;
            grace_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                phases_reg <= phases;
                grace_reg  <= grace_next;
            end
            if (cfg_fire && (cfg_index == CFG_STEPS_PER_DETENT))
            begin
                acc_reg <= '0;
            end
            else if (in_fire)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    // output beat register with one skid entry
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(rkqb_result_t)){1'b0}}, out_data_reg};

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_data_next  = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a pending output beat");

    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_data_reg.input_enabled) |->
        (out_data_reg.step == 2'sd0) && !out_data_reg.press_pulse
        && !out_data_reg.hold_level && !out_data_reg.sleep_pulse)
        else $error("output beat during grace period is not all zero");

    a_press_sleep_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_data_reg.press_pulse && out_data_reg.sleep_pulse))
        else $error("press and sleep pulse in the same beat");

    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg < spd_s) && (acc_reg > -spd_s))
        else $error("tick accumulator outside detent range");

endmodule

`default_nettype wire
